@@ rtl/core/effective_priority_thread_scheduler_core_assert.svh @@
// Assertion macros for the scheduler core checker.
`ifndef EFFECTIVE_PRIORITY_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define EFFECTIVE_PRIORITY_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define EPTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EPTS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/core/epts_pkg.sv @@
// Shared constants and types for the effective priority thread scheduler.
package epts_pkg;
    localparam int SLOTS_DEF = 16;
    localparam logic [30:0] WRAP_RESET = 31'd1048576;
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_SLEEP = 2'd2;
    localparam logic [1:0] REQ_WAKE  = 2'd3;
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_BUSY  = 2'd2;
    localparam logic [1:0] ERR_NOCUR = 2'd3;
    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_SLEEP = 2'd2;
    typedef logic [1:0] t_mode;
endpackage

@@ rtl/core/effective_priority_thread_scheduler_core.sv @@
// Top level: sequenced thread scheduler over a slot table.
// channel  | dir | handshake
// in       | in  | i_valid / o_ready, fields i_req_type..i_channel
// out      | out | o_valid / i_ready, fields o_current_slot..o_error_code
// cfg      | in  | i_cfg_we / i_cfg_wdata (wrap_limit)
// Scan and wrap passes visit one slot per cycle through a shared compare/add
// unit. A sleep with no running thread skips the scan; a wake walks the sleep
// queue newest to oldest and then packs it.
// Synchronous active-low reset clears control and used/mode bits only.
// Input not ready from transfer until the cycle after the result transfers.
module effective_priority_thread_scheduler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_thread_slot,
    input  logic [7:0]  i_base,
    input  logic [7:0]  i_boost,
    input  logic [31:0] i_channel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_current_slot,
    output logic        o_current_valid,
    output logic        o_switched,
    output logic [4:0]  o_woken_count,
    output logic [1:0]  o_error_code,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);
    import epts_pkg::*;
    localparam int SLOTS = SLOTS_DEF;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHG  = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_WRAP = 4'd3;
    localparam logic [3:0] S_SEL  = 4'd4;
    localparam logic [3:0] S_WAKE = 4'd5;
    localparam logic [3:0] S_CMPC = 4'd6;
    localparam logic [3:0] S_PACK = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_REL  = 4'd9;

    logic [3:0] r_state;
    logic [30:0] r_wrap;
    logic [SLOTS-1:0] r_used;
    t_mode r_mode [SLOTS];
    logic [7:0] r_base [SLOTS];
    logic [7:0] r_bst [SLOTS];
    logic [31:0] r_eff [SLOTS];
    logic [31:0] r_chan [SLOTS];
    logic [SW-1:0] r_q [SLOTS];
    logic [SLOTS-1:0] r_qdel;
    logic [CW-1:0] r_qcnt;
    logic [SW-1:0] r_run;
    logic r_rv;
    logic [1:0] r_req;
    logic [3:0] r_slot;
    logic [7:0] r_ibase, r_ibst;
    logic [31:0] r_ichan;
    logic [CW-1:0] r_i, r_keep;
    logic r_found, r_higher, r_sw;
    logic [SW-1:0] r_best;
    logic [31:0] r_bkey, r_rel;
    logic [4:0] r_woken;
    logic [1:0] r_err;
    logic r_ov;
    logic [SW-1:0] r_ocs;
    logic r_ocv;
    logic r_osw;
    logic [4:0] r_owk;
    logic [1:0] r_oerr;

    logic [SW-1:0] w_i;
    logic [SW-1:0] w_qs;
    logic [8:0] w_b;
    logic [7:0] w_bs;
    logic [31:0] w_key, w_new;
    assign w_i = r_i[SW-1:0];
    assign w_qs = r_q[w_i];
    assign w_b = {1'b0, r_bst[w_qs]} + {4'd0, r_woken};
    assign w_bs = w_b[8] ? 8'hFF : w_b[7:0];
    assign w_key = r_eff[w_i] ^ 32'h8000_0000;
    // wake adder: relative placement = base - sat(boost + woken) + rel
    assign w_new = {24'd0, r_base[w_qs]} - {24'd0, w_bs} + r_rel;

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_current_slot = 4'(r_ocs);
    assign o_current_valid = r_ocv;
    assign o_switched = r_osw;
    assign o_woken_count = r_owk;
    assign o_error_code = r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wrap <= WRAP_RESET;
            r_used <= '0;
            for (int k = 0; k < SLOTS; k++) r_mode[k] <= MODE_READY;
            r_qcnt <= '0;
            r_run <= '0;
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) r_wrap <= i_cfg_wdata;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req <= i_req_type; r_slot <= i_thread_slot;
                        r_ibase <= i_base; r_ibst <= i_boost; r_ichan <= i_channel;
                        r_woken <= '0; r_err <= ERR_OK; r_sw <= 1'b0;
                        r_higher <= 1'b0; r_found <= 1'b0; r_i <= '0;
                        r_rel <= r_rv ? r_eff[r_run] - ({24'd0, r_base[r_run]}
                                 - {24'd0, r_bst[r_run]}) : 32'd0;
                        unique case (i_req_type)
                            REQ_ADD: r_state <= S_SEL;
                            REQ_TICK: r_state <= S_CHG;
                            REQ_SLEEP: begin
                                if (!r_rv) begin
                                    r_err <= ERR_NOCUR; r_state <= S_OUT;
                                end else begin
                                    r_state <= S_CHG;
                                end
                            end
                            default: begin
                                r_i <= r_qcnt; r_qdel <= '0; r_state <= S_WAKE;
                            end
                        endcase
                    end
                end
                S_SEL: begin  // add
                    if ({1'b0, r_slot} >= 5'(SLOTS) || r_used[SW'(r_slot)]) begin
                        r_err <= ERR_BUSY;
                    end else begin
                        r_eff[SW'(r_slot)] <= r_rv ? ({24'd0, r_ibase} - {24'd0, r_ibst}
                                              + r_rel) : 32'd0;
                        r_used[SW'(r_slot)] <= 1'b1;
                        r_mode[SW'(r_slot)] <= MODE_READY;
                        r_base[SW'(r_slot)] <= r_ibase;
                        r_bst[SW'(r_slot)] <= r_ibst;
                    end
                    r_state <= S_OUT;
                end
                S_CHG: begin
                    if (r_req == REQ_SLEEP) begin
                        logic [7:0] nb;
                        nb = (r_ibst > r_bst[r_run]) ? r_ibst : r_bst[r_run];
                        r_bst[r_run] <= nb;
                        r_eff[r_run] <= {24'd0, r_base[r_run]} + {24'd0, nb};
                        r_chan[r_run] <= r_ichan;
                        r_mode[r_run] <= MODE_SLEEP;
                        if (r_qcnt < CW'(SLOTS)) begin
                            r_q[r_qcnt[SW-1:0]] <= r_run;
                            r_qcnt <= r_qcnt + 1'b1;
                        end
                    end else if (r_rv) begin
                        r_eff[r_run] <= r_eff[r_run] + {24'd0, r_base[r_run]}
                                        + ((r_bst[r_run] != 0) ? 32'd1 : 32'd0);
                        if (r_bst[r_run] != 0) r_bst[r_run] <= r_bst[r_run] - 1'b1;
                        r_mode[r_run] <= MODE_READY;
                    end
                    r_rv <= 1'b0;
                    r_i <= '0; r_found <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_used[w_i] && r_mode[w_i] == MODE_READY
                        && (!r_found || w_key < r_bkey)) begin
                        r_found <= 1'b1; r_best <= w_i; r_bkey <= w_key;
                    end
                    if (r_i == CW'(SLOTS - 1)) begin
                        r_i <= '0;
                        r_state <= S_REL;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_REL: begin
                    if (!r_found) begin
                        r_err <= ERR_EMPTY; r_sw <= 1'b0; r_state <= S_OUT;
                    end else if (r_bkey >= ({1'b0, r_wrap} ^ 32'h8000_0000)) begin
                        r_state <= S_WRAP;
                    end else begin
                        r_run <= r_best; r_rv <= 1'b1; r_mode[r_best] <= MODE_RUN;
                        r_sw <= 1'b1; r_state <= S_OUT;
                    end
                end
                S_WRAP: begin
                    if (r_used[w_i] && r_mode[w_i] == MODE_READY)
                        r_eff[w_i] <= r_eff[w_i] - {1'b0, r_wrap};
                    if (r_i == CW'(SLOTS - 1)) begin
                        r_run <= r_best; r_rv <= 1'b1; r_mode[r_best] <= MODE_RUN;
                        r_sw <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_WAKE: begin  // newest to oldest, each entry stepped here and compared in S_CMPC
                    if (r_i == '0) begin
                        r_i <= '0; r_keep <= '0; r_state <= S_PACK;
                    end else begin
                        r_i <= r_i - 1'b1;
                        r_state <= S_CMPC;
                    end
                end
                S_CMPC: begin
                    if (r_chan[w_qs] == r_ichan) begin
                        r_woken <= r_woken + 1'b1;
                        r_bst[w_qs] <= w_bs;
                        r_eff[w_qs] <= w_new;
                        r_mode[w_qs] <= MODE_READY;
                        r_qdel[w_i] <= 1'b1;
                        if (!r_rv || ((w_new ^ 32'h8000_0000)
                                      < (r_eff[r_run] ^ 32'h8000_0000)))
                            r_higher <= 1'b1;
                    end
                    r_state <= S_WAKE;
                end
                S_PACK: begin
                    if (r_i == r_qcnt) begin
                        r_qcnt <= r_keep;
                        if (r_higher) begin
                            r_state <= S_CHG;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        if (!r_qdel[w_i]) begin
                            r_q[r_keep[SW-1:0]] <= r_q[w_i];
                            r_keep <= r_keep + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    r_ocs <= r_rv ? r_run : '0;
                    r_ocv <= r_rv;
                    r_osw <= r_sw;
                    r_owk <= r_woken;
                    r_oerr <= r_err;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/core/epts_checker.sv @@
// Port-level checker for the scheduler core, bound to the top level.
`include "effective_priority_thread_scheduler_core_assert.svh"
module epts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_current_slot,
    input logic       o_current_valid,
    input logic [1:0] o_error_code,
    input logic [4:0] o_woken_count
);
    import epts_pkg::*;
    `EPTS_ASSERT(a_no_ready_with_out, i_clk, i_rst_n, o_valid |-> !o_ready, "ready while result pending")
    `EPTS_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped")
    `EPTS_ASSERT(a_idle_slot, i_clk, i_rst_n, (o_valid && !o_current_valid) |-> o_current_slot == 4'd0, "slot without thread")
    `EPTS_ASSERT(a_busy_nowoken, i_clk, i_rst_n, (o_valid && o_error_code == ERR_BUSY) |-> o_woken_count == 5'd0, "woken on add")
    `EPTS_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule
bind effective_priority_thread_scheduler_core epts_checker u_chk (.*);
